// ----- design/ssu_pkg.sv -----
// ----------------------------------------------------------------------------
// Sprite span set update package
// Shared constants, size tables and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ssu_pkg;

  localparam int SCREEN_COLUMNS = 240;
  localparam int SCREEN_ROWS    = 160;
  localparam int SPRITE_COUNT   = 128;

  localparam int IDX_W   = 7;
  localparam int LEN_W   = 8;
  localparam int CLIP_W  = 11;
  localparam int MAX_DIM = (SCREEN_COLUMNS > SCREEN_ROWS) ? SCREEN_COLUMNS : SCREEN_ROWS;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CNT_W   = (DIM_W > LEN_W) ? DIM_W : LEN_W;
  localparam int SUM_W   = CNT_W + 1;
  localparam int COL_AW  = $clog2(SCREEN_COLUMNS);
  localparam int ROW_AW  = $clog2(SCREEN_ROWS);

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } sprite_op_t;

  typedef enum logic [1:0] {
    SHAPE_SQUARE = 2'd0,
    SHAPE_WIDE   = 2'd1,
    SHAPE_TALL   = 2'd2,
    SHAPE_NONE   = 2'd3
  } shape_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic setup;
    logic col_step;
    logic cnt_zero;
    logic row_step;
    logic res_load;
  } ssu_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic col_end;
    logic row_end;
  } ssu_status_t;

  function automatic logic [LEN_W-1:0] base_width(input logic [1:0] shape,
                                                  input logic [1:0] size);
    logic [LEN_W-1:0] w;
    w = '0;
    unique case (shape_t'(shape))
      SHAPE_SQUARE: w = LEN_W'(8) << size;
      SHAPE_WIDE: begin
        unique case (size)
          2'd0:    w = LEN_W'(16);
          2'd1:    w = LEN_W'(32);
          2'd2:    w = LEN_W'(32);
          default: w = LEN_W'(64);
        endcase
      end
      SHAPE_TALL: begin
        unique case (size)
          2'd0:    w = LEN_W'(8);
          2'd1:    w = LEN_W'(8);
          2'd2:    w = LEN_W'(16);
          default: w = LEN_W'(32);
        endcase
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [LEN_W-1:0] base_height(input logic [1:0] shape,
                                                   input logic [1:0] size);
    logic [LEN_W-1:0] h;
    h = '0;
    unique case (shape_t'(shape))
      SHAPE_SQUARE: h = base_width(shape, size);
      SHAPE_WIDE:   h = base_width(SHAPE_TALL, size);
      SHAPE_TALL:   h = base_width(SHAPE_WIDE, size);
      default:      h = '0;
    endcase
    return h;
  endfunction

endpackage

// ----- design/sprite_span_set_update_unit.sv -----
// xl and yl are the clipped column and row span lengths (at most 128 each); the column
// and row sweeps visit one memory entry per cycle. Items are handled one at a time; the next
// input transaction is taken while a finished result still waits in the output register.
// Reset: synchronous, active low; a clearing pass over every column and row entry follows
// with in_tready low.
// ----------------------------------------------------------------------------
// Sprite span set update unit
// Adds or removes one sprite from per-column and per-row coverage bit sets.
// ----------------------------------------------------------------------------
module sprite_span_set_update_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // opcode[0], sprite_index[7:1], is_affine[8], mode_flag[9], x_pos[18:10],
  // y_pos[26:19], shape_code[28:27], size_code[30:29], zero[31]
  input  logic [ssu_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // done_res[0], columns_touched[8:1], zero[15:9]
  output logic [ssu_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  ssu_pkg::ssu_cmd_t    cmd;
  ssu_pkg::ssu_status_t status;

  ssu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  ssu_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

`ifndef NO_ASSERTIONS
  a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.res_load))
    else $error("Result raised without a result load.");

  a_cols_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8:1] <= 8'd128) && out_tdata[0])
    else $error("Result carries an impossible column count.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready && cmd.setup)
    else $error("Accepted item did not enter setup.");

  a_one_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.col_step |=> !cmd.clr_step && !cmd.load)
    else $error("Column sweep interrupted.");
`endif

endmodule

// ----- design/ssu_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sprite span set update controller
// Sequences the clearing pass, span setup, column and row sweeps and result.
// ----------------------------------------------------------------------------
module ssu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  ssu_pkg::ssu_status_t status,
  output ssu_pkg::ssu_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_COLS,
    ST_ROWS,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_COLS;
      end
      ST_COLS: begin
        if (status.col_end) begin
          cmd.cnt_zero = 1'b1;
          state_nxt    = ST_ROWS;
        end else begin
          cmd.col_step = 1'b1;
        end
      end
      ST_ROWS: begin
        if (status.row_end) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.row_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/ssu_datapath.sv -----
// ----------------------------------------------------------------------------
// Sprite span set update datapath
// Span clipping, sweep counter, column and row set memories and result.
// ----------------------------------------------------------------------------
module ssu_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ssu_pkg::ssu_cmd_t                     cmd,
  output ssu_pkg::ssu_status_t                  status,
  input  logic [ssu_pkg::IN_TDATA_W-1:0]        in_tdata,
  output logic [ssu_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  localparam int SC = ssu_pkg::SPRITE_COUNT;

  logic                                opcode_r;
  logic [ssu_pkg::IDX_W-1:0]           idx_r;
  logic                                affine_r;
  logic                                flag_r;
  logic signed [8:0]                   x_r;
  logic signed [7:0]                   y_r;
  logic [1:0]                          shape_r;
  logic [1:0]                          size_r;

  logic [7:0]                          xf_r, yf_r;
  logic [ssu_pkg::LEN_W-1:0]           xl_r, yl_r;
  logic [SC-1:0]                       mask_r;
  logic [ssu_pkg::CNT_W-1:0]           cnt_r;
  logic [ssu_pkg::LEN_W-1:0]           res_cols_r;

  logic                                enable;
  logic                                remove_op;
  logic [ssu_pkg::LEN_W-1:0]           w, h;
  logic signed [ssu_pkg::CLIP_W-1:0]   x_ext, x_end, x_start, x_lim, x_endc;
  logic signed [ssu_pkg::CLIP_W-1:0]   y_ext, y_end, y_start, y_lim, y_endc;
  logic [ssu_pkg::LEN_W-1:0]           xl_nxt, yl_nxt;
  logic [SC-1:0]                       mask_nxt;

  logic [SC-1:0]                       col_mem [ssu_pkg::SCREEN_COLUMNS];
  logic [SC-1:0]                       row_mem [ssu_pkg::SCREEN_ROWS];
  logic [SC-1:0]                       col_rd_r, row_rd_r;
  logic [ssu_pkg::COL_AW-1:0]          col_wa_r, col_ra, col_wa;
  logic [ssu_pkg::ROW_AW-1:0]          row_wa_r, row_ra, row_wa;
  logic                                col_pend_r, row_pend_r;
  logic                                col_we, row_we;
  logic [SC-1:0]                       col_wd, row_wd;
  logic [ssu_pkg::SUM_W-1:0]           col_sum, row_sum;
  logic                                clr_col, clr_row;

  // Setup arithmetic on the captured item.
  always_comb begin
    enable  = ({1'b0, idx_r} < (ssu_pkg::IDX_W + 1)'(SC)) && !(!affine_r && flag_r);
    w       = ssu_pkg::base_width(shape_r, size_r) << flag_r;
    h       = ssu_pkg::base_height(shape_r, size_r) << flag_r;

    x_ext   = ssu_pkg::CLIP_W'(x_r);
    x_end   = x_ext + $signed({{(ssu_pkg::CLIP_W - ssu_pkg::LEN_W){1'b0}}, w});
    x_start = x_r[8] ? '0 : x_ext;
    x_lim   = ssu_pkg::CLIP_W'(ssu_pkg::SCREEN_COLUMNS);
    x_endc  = (x_end > x_lim) ? x_lim : x_end;
    xl_nxt  = (enable && (x_endc > x_start)) ? ssu_pkg::LEN_W'(x_endc - x_start) : '0;

    y_ext   = ssu_pkg::CLIP_W'(y_r);
    y_end   = y_ext + $signed({{(ssu_pkg::CLIP_W - ssu_pkg::LEN_W){1'b0}}, h});
    y_start = y_r[7] ? '0 : y_ext;
    y_lim   = ssu_pkg::CLIP_W'(ssu_pkg::SCREEN_ROWS);
    y_endc  = (y_end > y_lim) ? y_lim : y_end;
    yl_nxt  = (enable && (y_endc > y_start)) ? ssu_pkg::LEN_W'(y_endc - y_start) : '0;

    for (int i = 0; i < SC; i++) begin
      mask_nxt[i] = (idx_r == ssu_pkg::IDX_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode_r <= in_tdata[0];
      idx_r    <= in_tdata[7:1];
      affine_r <= in_tdata[8];
      flag_r   <= in_tdata[9];
      x_r      <= in_tdata[18:10];
      y_r      <= in_tdata[26:19];
      shape_r  <= in_tdata[28:27];
      size_r   <= in_tdata[30:29];
    end
    if (cmd.setup) begin
      xf_r   <= x_start[7:0];
      yf_r   <= y_start[7:0];
      xl_r   <= xl_nxt;
      yl_r   <= yl_nxt;
      mask_r <= mask_nxt;
    end
    if (cmd.res_load) begin
      res_cols_r <= xl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      col_pend_r <= 1'b0;
      row_pend_r <= 1'b0;
    end else begin
      if (cmd.setup || cmd.cnt_zero || (cmd.clr_step && status.clr_last)) begin
        cnt_r <= '0;
      end else if (cmd.clr_step || cmd.col_step || cmd.row_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      col_pend_r <= cmd.col_step;
      row_pend_r <= cmd.row_step;
    end
  end

  assign status.clr_last = (cnt_r == ssu_pkg::CNT_W'(ssu_pkg::MAX_DIM - 1));
  assign status.col_end  = (cnt_r == ssu_pkg::CNT_W'(xl_r));
  assign status.row_end  = (cnt_r == ssu_pkg::CNT_W'(yl_r));

  // Read-modify-write sweep: read one entry per cycle, write it back next cycle.
  assign col_sum = ssu_pkg::SUM_W'(xf_r) + ssu_pkg::SUM_W'(cnt_r);
  assign row_sum = ssu_pkg::SUM_W'(yf_r) + ssu_pkg::SUM_W'(cnt_r);
  assign col_ra  = col_sum[ssu_pkg::COL_AW-1:0];
  assign row_ra  = row_sum[ssu_pkg::ROW_AW-1:0];

  assign clr_col = cmd.clr_step && (cnt_r < ssu_pkg::CNT_W'(ssu_pkg::SCREEN_COLUMNS));
  assign clr_row = cmd.clr_step && (cnt_r < ssu_pkg::CNT_W'(ssu_pkg::SCREEN_ROWS));

  assign remove_op = (opcode_r == ssu_pkg::OP_REMOVE);

  assign col_we = clr_col || col_pend_r;
  assign row_we = clr_row || row_pend_r;
  assign col_wa = clr_col ? cnt_r[ssu_pkg::COL_AW-1:0] : col_wa_r;
  assign row_wa = clr_row ? cnt_r[ssu_pkg::ROW_AW-1:0] : row_wa_r;
  assign col_wd = clr_col ? '0 : (remove_op ? (col_rd_r & ~mask_r) : (col_rd_r | mask_r));
  assign row_wd = clr_row ? '0 : (remove_op ? (row_rd_r & ~mask_r) : (row_rd_r | mask_r));

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_wa] <= col_wd;
    end
    if (cmd.col_step) begin
      col_rd_r <= col_mem[col_ra];
      col_wa_r <= col_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (cmd.row_step) begin
      row_rd_r <= row_mem[row_ra];
      row_wa_r <= row_ra;
    end
  end

  assign out_tdata = {{(ssu_pkg::OUT_TDATA_W - ssu_pkg::LEN_W - 1){1'b0}}, res_cols_r, 1'b1};

endmodule
